@@ hw/rtl/dssb_pkg.sv @@
// ----------------------------------------------------------------------------
// dssb_pkg
// Shared types and codes for the dual stack shared buffer block.
// ----------------------------------------------------------------------------
package dssb_pkg;

  localparam int SIZE_W = 11;
  localparam int DATA_W = 32;
  localparam int STATUS_W = 2;

  localparam logic [SIZE_W-1:0] CAPACITY_RESET = 11'd1024;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // stack select codes
  localparam logic SEL_ONE = 1'b0;
  localparam logic SEL_TWO = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // result of one item, held while its read data comes back from the buffer
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                pop_ok;
    logic [SIZE_W-1:0]   size_one;
    logic [SIZE_W-1:0]   size_two;
  } result_t;

endpackage

@@ hw/rtl/dssb_ram.sv @@
// ----------------------------------------------------------------------------
// dssb_ram
// Single write port, single read port buffer with registered read data.
// ----------------------------------------------------------------------------
module dssb_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [dssb_pkg::DATA_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [dssb_pkg::DATA_W-1:0] rd_data
);

  logic [dssb_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/dual_stack_shared_buffer.sv @@
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer
// Two LIFO stacks in one buffer: stack one grows up from entry 0, stack two
// grows down from the top of the configured capacity.
//
// Input channel (item_valid / item_stall): operation (0 push, 1 pop),
// stack_select (0 stack one, 1 stack two) and push_value. Each item gives
// exactly one result on the result channel (result_valid / result_stall):
// status, pop_value and both stack sizes after the operation.
// An accepted item passes through the read stage and then the output
// register, where result_valid rises; one item per cycle is sustained while
// the receiver does not stall. The registered read data of the buffer memory
// is taken into the output register as the item leaves the read stage.
// The stack counts are updated as the item is accepted, so the next item
// sees them at once. When the receiver stalls, the result is held in the
// output register and one more item may sit in the read stage; after that
// item_stall is raised until the output moves.
// Writing capacity (cfg_wr_en) clears both stacks; write it only while idle.
// Reset empties both stacks and sets capacity to 1024 (or DEPTH if smaller).
// The buffer itself is not cleared; no entry is read before it is written.
// ----------------------------------------------------------------------------
module dual_stack_shared_buffer #(
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [dssb_pkg::SIZE_W-1:0]          cfg_wr_data,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 operation,
  input  logic                                 stack_select,
  input  logic signed [dssb_pkg::DATA_W-1:0]   push_value,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [dssb_pkg::STATUS_W-1:0]        status,
  output logic signed [dssb_pkg::DATA_W-1:0]   pop_value,
  output logic [dssb_pkg::SIZE_W-1:0]          size_one,
  output logic [dssb_pkg::SIZE_W-1:0]          size_two
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SW = dssb_pkg::SIZE_W;
  localparam logic [SW-1:0] CAP_RESET =
    (DEPTH < 32'(dssb_pkg::CAPACITY_RESET)) ? SW'(DEPTH) : dssb_pkg::CAPACITY_RESET;

  logic [SW-1:0] count_one;
  logic [SW-1:0] count_two;
  logic [SW-1:0] cap_eff;
  logic [SW-1:0] count_one_next;
  logic [SW-1:0] count_two_next;
  logic [SW-1:0] cap_cfg;

  logic          accept;
  logic          out_free;
  logic          p1_valid;
  dssb_pkg::result_t p1;
  dssb_pkg::result_t res_next;

  logic [SW:0]   used;
  logic          can_push;
  logic [SW-1:0] sel_count;
  logic          can_pop;
  logic [SW-1:0] push_idx;
  logic [SW-1:0] pop_idx;

  logic                        wr_en;
  logic                        rd_en;
  logic [dssb_pkg::DATA_W-1:0] rd_data;

  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = p1_valid && !out_free;

  // saturate the written capacity at the buffer depth
  assign cap_cfg = (32'(cfg_wr_data) > DEPTH) ? SW'(DEPTH) : cfg_wr_data;

  assign used      = {1'b0, count_one} + {1'b0, count_two};
  assign can_push  = used < {1'b0, cap_eff};
  assign sel_count = (stack_select == dssb_pkg::SEL_TWO) ? count_two : count_one;
  assign can_pop   = (sel_count != '0) && (sel_count <= cap_eff);

  assign push_idx = (stack_select == dssb_pkg::SEL_TWO) ?
                    (cap_eff - count_two - SW'(1)) : count_one;
  assign pop_idx  = (stack_select == dssb_pkg::SEL_TWO) ?
                    (cap_eff - count_two) : (count_one - SW'(1));

  always_comb begin
    count_one_next   = count_one;
    count_two_next   = count_two;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    res_next.status  = dssb_pkg::ST_OK;
    res_next.pop_ok  = 1'b0;
    if (operation == dssb_pkg::OP_PUSH) begin
      if (can_push) begin
        wr_en = accept;
        if (stack_select == dssb_pkg::SEL_TWO) begin
          count_two_next = count_two + SW'(1);
        end else begin
          count_one_next = count_one + SW'(1);
        end
      end else begin
        res_next.status = dssb_pkg::ST_OVERFLOW;
      end
    end else begin
      if (can_pop) begin
        rd_en           = accept;
        res_next.pop_ok = 1'b1;
        if (stack_select == dssb_pkg::SEL_TWO) begin
          count_two_next = count_two - SW'(1);
        end else begin
          count_one_next = count_one - SW'(1);
        end
      end else begin
        res_next.status = dssb_pkg::ST_UNDERFLOW;
      end
    end
    res_next.size_one = count_one_next;
    res_next.size_two = count_two_next;
  end

  dssb_ram #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(ADDR_W'(push_idx)),
    .wr_data(push_value),
    .rd_en  (rd_en),
    .rd_addr(ADDR_W'(pop_idx)),
    .rd_data(rd_data)
  );

  // stack counts and effective capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      count_one <= '0;
      count_two <= '0;
      cap_eff   <= CAP_RESET;
    end else if (cfg_wr_en) begin
      count_one <= '0;
      count_two <= '0;
      cap_eff   <= cap_cfg;
    end else if (accept) begin
      count_one <= count_one_next;
      count_two <= count_two_next;
    end
  end

  // read stage: hold the item while its buffer data comes back
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (out_free) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1 <= res_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && p1_valid) begin
      status    <= p1.status;
      pop_value <= p1.pop_ok ? rd_data : '0;
      size_one  <= p1.size_one;
      size_two  <= p1.size_two;
    end
  end

  a_counts_fit: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, count_one} + {1'b0, count_two}) <= {1'b0, cap_eff})
    else $error("stack counts exceed capacity");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (p1_valid && result_valid))
    else $error("input stalled with a free stage");

  a_pop_reaches_stage: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (p1_valid && p1.pop_ok))
    else $error("buffer read without a pending pop");

  a_fail_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != dssb_pkg::ST_OK) |-> (pop_value == '0))
    else $error("failed item carries a value");

endmodule

@@ tb/sv/dual_stack_shared_buffer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer_test
// Self-checking bench for the dual stack shared buffer. A scoreboard mirrors
// both stacks and the capacity register, predicts status, popped value and
// both sizes for every accepted item, and compares them in order with the
// results. Directed pushes and pops cover the edge cases, then random
// phases under several capacities run, all but the last with random gaps on both channels.
// ----------------------------------------------------------------------------
module dual_stack_shared_buffer_test;

  localparam int STACK_DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD = 40;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES = 10;

  typedef struct {
    logic [dssb_pkg::STATUS_W-1:0] status;
    logic [dssb_pkg::DATA_W-1:0]   pop_value;
    logic [dssb_pkg::SIZE_W-1:0]   size_one;
    logic [dssb_pkg::SIZE_W-1:0]   size_two;
  } stack_result_t;

  class stack_scoreboard;
    logic [dssb_pkg::DATA_W-1:0] entries [STACK_DEPTH];
    int unsigned depth_one;
    int unsigned depth_two;
    int unsigned capacity;
    stack_result_t expected_q[$];
    int errors;

    function new();
      depth_one = 0;
      depth_two = 0;
      capacity = 1024;
      errors = 0;
    endfunction

    function void set_capacity(logic [dssb_pkg::SIZE_W-1:0] value);
      capacity = 32'(value);
      depth_one = 0;
      depth_two = 0;
    endfunction

    function void note_item(logic op, logic sel, logic [dssb_pkg::DATA_W-1:0] value);
      stack_result_t res;
      int unsigned cap;
      int unsigned slot;
      int unsigned cnt;
      cap = (capacity > STACK_DEPTH) ? STACK_DEPTH : capacity;
      res.status = dssb_pkg::ST_OK;
      res.pop_value = '0;
      if (op == dssb_pkg::OP_PUSH) begin
        if (depth_one + depth_two < cap) begin
          if (sel == dssb_pkg::SEL_TWO) begin
            slot = cap - depth_two - 1;
            depth_two++;
          end else begin
            slot = depth_one;
            depth_one++;
          end
          entries[slot] = value;
        end else begin
          res.status = dssb_pkg::ST_OVERFLOW;
        end
      end else begin
        cnt = (sel == dssb_pkg::SEL_TWO) ? depth_two : depth_one;
        if (cnt == 0 || cnt > cap) begin
          res.status = dssb_pkg::ST_UNDERFLOW;
        end else if (sel == dssb_pkg::SEL_TWO) begin
          res.pop_value = entries[cap - depth_two];
          depth_two--;
        end else begin
          res.pop_value = entries[depth_one - 1];
          depth_one--;
        end
      end
      res.size_one = depth_one[dssb_pkg::SIZE_W-1:0];
      res.size_two = depth_two[dssb_pkg::SIZE_W-1:0];
      expected_q.push_back(res);
    endfunction

    function void check_result(stack_result_t got);
      stack_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d pop_value %h sizes %0d %0d",
                 $time, got.status, got.pop_value, got.size_one, got.size_two);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.pop_value !== want.pop_value) begin
        $display("%0t: pop_value expected %h actual %h", $time, want.pop_value,
                 got.pop_value);
        errors++;
      end
      if (got.size_one !== want.size_one) begin
        $display("%0t: size_one expected %0d actual %0d", $time, want.size_one,
                 got.size_one);
        errors++;
      end
      if (got.size_two !== want.size_two) begin
        $display("%0t: size_two expected %0d actual %0d", $time, want.size_two,
                 got.size_two);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [dssb_pkg::SIZE_W-1:0] cfg_wr_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic operation = dssb_pkg::OP_PUSH;
  logic stack_select = dssb_pkg::SEL_ONE;
  logic signed [dssb_pkg::DATA_W-1:0] push_value = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [dssb_pkg::STATUS_W-1:0] status;
  logic signed [dssb_pkg::DATA_W-1:0] pop_value;
  logic [dssb_pkg::SIZE_W-1:0] size_one;
  logic [dssb_pkg::SIZE_W-1:0] size_two;

  stack_scoreboard board = new();
  bit idle_on = 1'b0;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  dual_stack_shared_buffer DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .stack_select (stack_select),
    .push_value   (push_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .pop_value    (pop_value),
    .size_one     (size_one),
    .size_two     (size_two)
  );

  always #5 clk = ~clk;

  // Sample both handshakes at the edge, before any update lands.
  always @(posedge clk) begin
    stack_result_t got;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        board.note_item(operation, stack_select, push_value);
        moved = 1'b1;
      end
      if (result_valid && !result_stall) begin
        got.status = status;
        got.pop_value = pop_value;
        got.size_one = size_one;
        got.size_two = size_two;
        board.check_result(got);
        moved = 1'b1;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(logic op, logic sel, logic [dssb_pkg::DATA_W-1:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    stack_select <= sel;
    push_value <= value;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [dssb_pkg::SIZE_W-1:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_capacity(value);
  endtask

  function automatic logic [dssb_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [dssb_pkg::SIZE_W-1:0] phase_caps [NUM_PHASES];
    int push_pct;
    phase_caps = '{11'd3, 11'd1, 11'd7, 11'd2047, 11'd16, 11'd0, 11'd5,
                   11'd64, 11'd1024, 11'd2};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty stacks, extreme values, order of return under reset capacity
    send_item(dssb_pkg::OP_POP, dssb_pkg::SEL_ONE, 32'h0);
    send_item(dssb_pkg::OP_POP, dssb_pkg::SEL_TWO, 32'h0);
    send_item(dssb_pkg::OP_PUSH, dssb_pkg::SEL_ONE, 32'h7FFF_FFFF);
    send_item(dssb_pkg::OP_PUSH, dssb_pkg::SEL_ONE, 32'h8000_0000);
    send_item(dssb_pkg::OP_PUSH, dssb_pkg::SEL_TWO, 32'hFFFF_FFFF);
    send_item(dssb_pkg::OP_PUSH, dssb_pkg::SEL_TWO, 32'h0000_0000);
    send_item(dssb_pkg::OP_POP, dssb_pkg::SEL_TWO, 32'h1234_5678);
    send_item(dssb_pkg::OP_POP, dssb_pkg::SEL_TWO, 32'h0);
    send_item(dssb_pkg::OP_POP, dssb_pkg::SEL_TWO, 32'h0);
    send_item(dssb_pkg::OP_POP, dssb_pkg::SEL_ONE, 32'h0);
    send_item(dssb_pkg::OP_POP, dssb_pkg::SEL_ONE, 32'h0);
    send_item(dssb_pkg::OP_POP, dssb_pkg::SEL_ONE, 32'h0);

    // tops meet: overflow on both sides
    write_capacity(11'd2);
    send_item(dssb_pkg::OP_PUSH, dssb_pkg::SEL_ONE, 32'hA5A5_A5A5);
    send_item(dssb_pkg::OP_PUSH, dssb_pkg::SEL_TWO, 32'h5A5A_5A5A);
    send_item(dssb_pkg::OP_PUSH, dssb_pkg::SEL_ONE, 32'h1111_1111);
    send_item(dssb_pkg::OP_PUSH, dssb_pkg::SEL_TWO, 32'h2222_2222);
    send_item(dssb_pkg::OP_POP, dssb_pkg::SEL_ONE, 32'h0);
    send_item(dssb_pkg::OP_POP, dssb_pkg::SEL_TWO, 32'h0);

    // no room at all
    write_capacity(11'd0);
    send_item(dssb_pkg::OP_PUSH, dssb_pkg::SEL_ONE, 32'hDEAD_BEEF);
    send_item(dssb_pkg::OP_PUSH, dssb_pkg::SEL_TWO, 32'hCAFE_F00D);
    send_item(dssb_pkg::OP_POP, dssb_pkg::SEL_ONE, 32'h0);

    // single entry owned by stack two
    write_capacity(11'd1);
    send_item(dssb_pkg::OP_PUSH, dssb_pkg::SEL_TWO, 32'h0BAD_CAFE);
    send_item(dssb_pkg::OP_PUSH, dssb_pkg::SEL_ONE, 32'h0000_0001);
    send_item(dssb_pkg::OP_POP, dssb_pkg::SEL_TWO, 32'h0);

    idle_on = 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      // no idling in the closing phase
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      if (p == 3) hold_request = 1'b1;
      push_pct = $urandom_range(35, 75);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_item(($urandom_range(0, 99) < push_pct) ? dssb_pkg::OP_PUSH
                                                      : dssb_pkg::OP_POP,
                  1'($urandom_range(0, 1)), pick_value());
      end
    end

    drain_results();
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
